// ===== design/pnc_pkg.sv =====
// pnc_pkg: shared types and constants for the pn sequence correlator
// no dependencies; imported by every other design file

package pnc_pkg;

	// array geometry
	localparam int LANES   = 4;
	localparam int PHASES  = 8;
	localparam int LANE_W  = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int PHASE_W = $clog2(PHASES);

	// field widths
	localparam int OP_W     = 2;
	localparam int WORD_W   = 32;
	localparam int LFSR_W   = 16;
	localparam int PN_W     = 8;
	localparam int ACC_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// register reset values
	localparam logic [LFSR_W-1:0] TAP_RESET  = 16'hD008;
	localparam logic [LFSR_W-1:0] SEED_RESET = 16'hABCD;

	typedef logic [ACC_W-1:0] acc_t;
	typedef logic [PN_W-1:0]  pn_t;

	// operation codes carried on the input word
	typedef enum logic [OP_W-1:0] {
		OP_RESTART   = 2'd0,
		OP_CORRELATE = 2'd1,
		OP_READOUT   = 2'd2
	} op_t;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAP_MASK = 1'b0,
		REG_SEED     = 1'b1
	} reg_idx_t;

	// per-word control from the top level to the lanes and generator
	typedef struct packed {
		logic restart;
		logic advance;
	} pnc_ctl_t;

endpackage

// ===== design/pnc_in_if.sv =====
// pnc_in_if: input channel, valid/ready with operation and sample word
// depends on pnc_pkg

interface pnc_in_if import pnc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [WORD_W-1:0] sample_word;

	modport source (output valid, output operation, output sample_word, input ready);
	modport sink   (input valid, input operation, input sample_word, output ready);
endinterface

// ===== design/pnc_out_if.sv =====
// pnc_out_if: result channel, valid/ready with one accumulator report
// depends on pnc_pkg

interface pnc_out_if import pnc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              lane;
	logic [2:0]              phase;
	logic signed [ACC_W-1:0] sum;
	logic                    last;

	modport source (output valid, output lane, output phase, output sum, output last,
		input ready);
	modport sink   (input valid, input lane, input phase, input sum, input last,
		output ready);
endinterface

// ===== design/pnc_pn_gen.sv =====
// pnc_pn_gen: galois lfsr and pn shift byte, eight steps unrolled per word
// depends on pnc_pkg

module pnc_pn_gen import pnc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  pnc_ctl_t          ctl,
	input  logic [LFSR_W-1:0] tap_mask,
	input  logic [LFSR_W-1:0] seed,
	output pn_t [PHASES-1:0]  pn_bytes
);

	logic [LFSR_W-1:0] lfsr_q;
	pn_t               pn_q;
	logic [LFSR_W-1:0] lfsr_next;
	pn_t               pn_next;

	// step the lfsr once per phase, shifting its output bit into the byte
	always_comb begin
		logic [LFSR_W-1:0] st;
		pn_t               pb;
		logic              bit_out;
		st = lfsr_q;
		pb = pn_q;
		for (int p = 0; p < PHASES; p++) begin
			bit_out = st[0];
			st = st >> 1;
			if (bit_out)
				st = st ^ tap_mask;
			pb = {pb[PN_W-2:0], bit_out};
			pn_bytes[p] = pb;
		end
		lfsr_next = st;
		pn_next   = pb;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= SEED_RESET;
			pn_q   <= '0;
		end else if (ctl.restart) begin
			lfsr_q <= seed;
			pn_q   <= '0;
		end else if (ctl.advance) begin
			lfsr_q <= lfsr_next;
			pn_q   <= pn_next;
		end
	end

endmodule

// ===== design/pnc_lane.sv =====
// pnc_lane: one byte lane, eight phase accumulators updated per word
// depends on pnc_pkg

module pnc_lane import pnc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  pnc_ctl_t          ctl,
	input  pn_t [PHASES-1:0]  pn_bytes,
	input  pn_t               sample_byte,
	output acc_t [PHASES-1:0] sums
);

	acc_t [PHASES-1:0] acc_q;
	acc_t [PHASES-1:0] acc_next;

	// add 2*popcount - 8 of the xor for every phase
	always_comb begin
		pn_t        x;
		logic [3:0] ones;
		for (int p = 0; p < PHASES; p++) begin
			x    = pn_bytes[p] ^ sample_byte;
			ones = '0;
			for (int b = 0; b < PN_W; b++)
				ones = ones + {3'b000, x[b]};
			acc_next[p] = acc_q[p] + {{(ACC_W-5){1'b0}}, ones, 1'b0} - acc_t'(PN_W);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_q <= '0;
		else if (ctl.restart)
			acc_q <= '0;
		else if (ctl.advance)
			acc_q <= acc_next;
	end

	assign sums = acc_q;

endmodule

// ===== design/pnc_readout.sv =====
// pnc_readout: merging stage, walks all lane sums into the output register
// depends on pnc_pkg and pnc_out_if

module pnc_readout import pnc_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  acc_t [LANES-1:0][PHASES-1:0]  sums,
	output logic                          busy,
	pnc_out_if.source                     result
);

	logic               busy_q;
	logic [LANE_W-1:0]  lane_q;
	logic [PHASE_W-1:0] phase_q;
	logic               valid_q;
	logic [1:0]         lane_out_q;
	logic [2:0]         phase_out_q;
	acc_t               sum_q;
	logic               last_q;
	logic               load;
	logic               at_end;
	logic [LANE_W+1:0]  lane_ext;

	assign at_end   = (lane_q == LANE_W'(LANES-1)) && (phase_q == PHASE_W'(PHASES-1));
	assign load     = busy_q && (!valid_q || result.ready);
	assign lane_ext = {2'b00, lane_q};

	// sequencer over lane-major order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			lane_q  <= '0;
			phase_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			lane_q  <= '0;
			phase_q <= '0;
		end else if (load) begin
			if (at_end)
				busy_q <= 1'b0;
			if (phase_q == PHASE_W'(PHASES-1)) begin
				phase_q <= '0;
				lane_q  <= lane_q + 1'b1;
			end else begin
				phase_q <= phase_q + 1'b1;
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (result.ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			lane_out_q  <= lane_ext[1:0];
			phase_out_q <= 3'(phase_q);
			sum_q       <= sums[lane_q][phase_q];
			last_q      <= at_end;
		end
	end

	assign busy         = busy_q;
	assign result.valid = valid_q;
	assign result.lane  = lane_out_q;
	assign result.phase = phase_out_q;
	assign result.sum   = sum_q;
	assign result.last  = last_q;

endmodule

// ===== design/pn_sequence_correlator.sv =====
// pn_sequence_correlator: lfsr pn correlator over four byte lanes
// restart and correlate words update the state on acceptance, one word per cycle while ready
// readout: the sequencer starts on acceptance, then one word per cycle for 32
// words, paced by the output register; input is held off until the last is loaded
// async active-low reset: registers to 0xD008/0xABCD, lfsr to 0xABCD, sums to zero
// depends on pnc_pkg, pnc_in_if, pnc_out_if, pnc_pn_gen, pnc_lane, pnc_readout

module pn_sequence_correlator import pnc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	pnc_in_if.sink                sample,
	pnc_out_if.source             result
);

	logic [LFSR_W-1:0]            tap_mask_q;
	logic [LFSR_W-1:0]            seed_q;
	logic                         busy;
	logic                         accept;
	op_t                          op;
	pnc_ctl_t                     ctl;
	pn_t [PHASES-1:0]             pn_bytes;
	acc_t [LANES-1:0][PHASES-1:0] sums;
	logic                         start;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_mask_q <= TAP_RESET;
			seed_q     <= SEED_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TAP_MASK: tap_mask_q <= cfg_data;
				REG_SEED:     seed_q     <= cfg_data;
				default:      ;
			endcase
		end
	end

	// decode the accepted word
	assign sample.ready = !busy;
	assign accept       = sample.valid && sample.ready;
	assign op           = op_t'(sample.operation);

	always_comb begin
		ctl   = '0;
		start = 1'b0;
		if (accept) begin
			unique case (op)
				OP_RESTART:   ctl.restart = 1'b1;
				OP_CORRELATE: ctl.advance = 1'b1;
				OP_READOUT:   start       = 1'b1;
				default:      ;
			endcase
		end
	end

	pnc_pn_gen u_pn_gen (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.tap_mask (tap_mask_q),
		.seed     (seed_q),
		.pn_bytes (pn_bytes)
	);

	// one correlator per byte lane; lanes past the word see a zero byte
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		pn_t lane_byte;
		if (l < 4) begin : g_in_word
			assign lane_byte = sample.sample_word[8*l +: 8];
		end else begin : g_past_word
			assign lane_byte = '0;
		end
		pnc_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.pn_bytes    (pn_bytes),
			.sample_byte (lane_byte),
			.sums        (sums[l])
		);
	end

	pnc_readout u_readout (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sums   (sums),
		.busy   (busy),
		.result (result)
	);

endmodule

// ===== design/pnc_checker.sv =====
// pnc_checker: port-level assertions for pn_sequence_correlator, bound to the top
// depends on pnc_pkg

module pnc_checker import pnc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_valid,
	input logic             s_ready,
	input logic [OP_W-1:0]  s_operation,
	input logic             r_valid,
	input logic             r_ready,
	input logic [1:0]       r_lane,
	input logic [2:0]       r_phase,
	input logic [ACC_W-1:0] r_sum,
	input logic             r_last
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_sum) && $stable(r_lane)
			&& $stable(r_phase) && $stable(r_last))
		else $error("stalled result word changed");

	// a readout blocks new input on the next cycle
	a_ro_block: assert property (@(posedge clk) disable iff (!arst_n)
		s_valid && s_ready && s_operation == OP_READOUT |=> !s_ready)
		else $error("input accepted right after readout");

	// while a run is unfinished no input is taken
	a_run_block: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_last |-> !s_ready)
		else $error("input ready during readout run");

	// words of a run follow back to back
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_ready && !r_last |=> r_valid)
		else $error("gap inside readout run");

	// last word is the final phase
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_last |-> r_phase == 3'(PHASES-1))
		else $error("last flag on wrong phase");

endmodule

bind pn_sequence_correlator pnc_checker u_pnc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.s_valid     (sample.valid),
	.s_ready     (sample.ready),
	.s_operation (sample.operation),
	.r_valid     (result.valid),
	.r_ready     (result.ready),
	.r_lane      (result.lane),
	.r_phase     (result.phase),
	.r_sum       (result.sum),
	.r_last      (result.last)
);

// ===== tb/pn_sequence_correlator_tb.sv =====
// pn_sequence_correlator_tb: self-checking bench for the lfsr pn correlator
// predicts every readout word from its own lfsr and accumulator model
// depends on pnc_pkg, pnc_in_if, pnc_out_if and pn_sequence_correlator
`timescale 1ns / 100ps

module pn_sequence_correlator_tb;
	import pnc_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 400_000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned RANDOM_WORDS  = 460;

	// operation code the block must ignore
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// one expected readout word
	typedef struct {
		logic [1:0]              lane;
		logic [2:0]              phase;
		logic signed [ACC_W-1:0] sum;
		logic                    last;
	} acc_report_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	reg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pnc_in_if  sample_ch ();
	pnc_out_if result_ch ();

	pn_sequence_correlator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	// correlator model state
	logic [LFSR_W-1:0] tap_model;
	logic [LFSR_W-1:0] seed_model;
	logic [LFSR_W-1:0] lfsr_model;
	pn_t               pn_model;
	acc_t              acc_model [LANES][PHASES];

	acc_report_t expected_reports [$];

	int unsigned mismatches = 0;
	int unsigned words_sent;
	int unsigned cycle_count = 0;
	int unsigned burst_left;
	int unsigned hold_request;
	logic        tx_gaps_on;
	logic        rx_stalls_on;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL pn_sequence_correlator");
			$finish;
		end
	end

	// ---------------------------------------------------------------- model

	function automatic void clear_model_run();
		lfsr_model = seed_model;
		pn_model   = '0;
		for (int l = 0; l < LANES; l++)
			for (int p = 0; p < PHASES; p++)
				acc_model[l][p] = '0;
	endfunction

	// step the lfsr once per phase and add each lane's mismatch score
	function automatic void correlate_model(input logic [WORD_W-1:0] word);
		logic       out_bit;
		pn_t        lane_byte;
		pn_t        diff;
		int         delta;
		for (int p = 0; p < PHASES; p++) begin
			out_bit    = lfsr_model[0];
			lfsr_model = lfsr_model >> 1;
			if (out_bit)
				lfsr_model = lfsr_model ^ tap_model;
			pn_model = {pn_model[PN_W-2:0], out_bit};
			for (int l = 0; l < LANES; l++) begin
				lane_byte = (l < 4) ? word[8*l +: 8] : '0;
				diff      = pn_model ^ lane_byte;
				delta     = 2 * $countones(diff) - 8;
				acc_model[l][p] = acc_model[l][p] + ACC_W'(delta);
			end
		end
	endfunction

	// queue all sums, lane-major
	function automatic void readout_model();
		acc_report_t rep;
		for (int l = 0; l < LANES; l++)
			for (int p = 0; p < PHASES; p++) begin
				rep.lane  = 2'(l);
				rep.phase = 3'(p);
				rep.sum   = acc_model[l][p];
				rep.last  = (l == LANES - 1) && (p == PHASES - 1);
				expected_reports.push_back(rep);
			end
	endfunction

	function automatic void predict_word(input logic [OP_W-1:0] op,
			input logic [WORD_W-1:0] word);
		case (op)
			OP_RESTART:   clear_model_run();
			OP_CORRELATE: correlate_model(word);
			OP_READOUT:   readout_model();
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	always @(posedge clk) begin : result_check
		acc_report_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_reports.size() == 0) begin
				report_mismatch("word with nothing pending, sum", int'(result_ch.sum), 0);
			end else begin
				want = expected_reports.pop_front();
				if (result_ch.lane !== want.lane)
					report_mismatch("lane", int'(result_ch.lane), int'(want.lane));
				if (result_ch.phase !== want.phase)
					report_mismatch("phase", int'(result_ch.phase), int'(want.phase));
				if (result_ch.sum !== want.sum)
					report_mismatch("sum", int'(result_ch.sum), int'(want.sum));
				if (result_ch.last !== want.last)
					report_mismatch("last", int'(result_ch.last), int'(want.last));
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// ready is high, or follows a rotating random pattern when stalls are on, or a long hold when requested
	initial begin : receiver_pacing
		int unsigned hold_left;
		int unsigned hold_taken;
		int unsigned age;
		logic [15:0] pattern;
		result_ch.ready = 1'b0;
		hold_left = 0;
		hold_taken = 0;
		age = 0;
		pattern = '1;
		forever begin
			@(negedge clk);
			if (hold_request != hold_taken) begin
				hold_left = hold_request;
				hold_taken = hold_request;
			end
			if (age == 0) begin
				pattern = 16'($urandom());
				age = $urandom_range(96, 16);
			end
			age--;
			if (hold_left != 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else if (!rx_stalls_on) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= pattern[0];
				pattern = {pattern[0], pattern[15:1]};
			end
		end
	end

	// ---------------------------------------------------------------- sender

	// offer one word, with a random gap between bursts when enabled
	task automatic send_word(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word);
		int unsigned gap;
		@(negedge clk);
		if (tx_gaps_on && burst_left == 0) begin
			gap = $urandom_range(8, 1);
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(16, 1);
		end
		if (burst_left != 0)
			burst_left--;
		sample_ch.valid       <= 1'b1;
		sample_ch.operation   <= op;
		sample_ch.sample_word <= word;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		predict_word(op, word);
		if (op != OP_UNUSED)
			words_sent++;
	endtask

	// stop offering, let every pending readout drain and the block settle
	task automatic drain_and_settle();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only while the block is idle
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TAP_MASK: tap_model  = value;
			REG_SEED:     seed_model = value;
			default: ;
		endcase
	endtask

	function automatic logic [LFSR_W-1:0] random_tap();
		case ($urandom_range(9))
			0: return 16'hD008;
			1: return 16'h0110;
			2: return 16'h0240;
			3: return 16'h0E08;
			4: return 16'h3802;
			5: return 16'h0000;
			6: return 16'hFFFF;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] random_sample();
		case ($urandom_range(11))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h5555_5555;
			3: return 32'hAAAA_AAAA;
			4: return {4{8'($urandom())}};
			default: return $urandom();
		endcase
	endfunction

	// ---------------------------------------------------------------- tests

	// sums read straight after reset are zero
	task automatic test_reset_readout();
		send_word(OP_READOUT, 32'h0);
		drain_and_settle();
	endtask

	// field extremes, every operation, the ignored code, restart clearing
	task automatic test_operations();
		send_word(OP_CORRELATE, 32'h0000_0000);
		send_word(OP_CORRELATE, 32'hFFFF_FFFF);
		send_word(OP_CORRELATE, 32'hAAAA_AAAA);
		send_word(OP_CORRELATE, 32'h5555_5555);
		send_word(OP_CORRELATE, 32'h0000_00FF);
		send_word(OP_CORRELATE, 32'h8000_0001);
		send_word(OP_READOUT, 32'hFFFF_FFFF);
		send_word(OP_UNUSED, 32'hFFFF_FFFF);
		send_word(OP_READOUT, 32'h0);
		send_word(OP_RESTART, 32'hFFFF_FFFF);
		send_word(OP_READOUT, 32'h0);
		drain_and_settle();
	endtask

	// zero seed keeps the pn stream at zero, then tap mask extremes
	task automatic test_register_extremes();
		write_reg(REG_SEED, 16'h0000);
		send_word(OP_RESTART, 32'h0);
		send_word(OP_CORRELATE, 32'hFFFF_FFFF);
		send_word(OP_CORRELATE, 32'h0F0F_F0F0);
		send_word(OP_READOUT, 32'h0);
		drain_and_settle();
		write_reg(REG_TAP_MASK, 16'hFFFF);
		write_reg(REG_SEED, 16'hFFFF);
		send_word(OP_RESTART, 32'h0);
		send_word(OP_CORRELATE, 32'h1234_5678);
		send_word(OP_CORRELATE, 32'hEDCB_A987);
		send_word(OP_READOUT, 32'h0);
		drain_and_settle();
		write_reg(REG_TAP_MASK, 16'h0000);
		write_reg(REG_SEED, 16'h0001);
		send_word(OP_RESTART, 32'h0);
		send_word(OP_CORRELATE, 32'hC3C3_3C3C);
		send_word(OP_READOUT, 32'h0);
		drain_and_settle();
	endtask

	// receiver holds off while words keep coming, so the input stalls
	task automatic test_backpressure();
		write_reg(REG_TAP_MASK, TAP_RESET);
		write_reg(REG_SEED, SEED_RESET);
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		hold_request = 400;
		send_word(OP_RESTART, 32'h0);
		send_word(OP_CORRELATE, random_sample());
		send_word(OP_READOUT, 32'h0);
		repeat (4) send_word(OP_CORRELATE, random_sample());
		send_word(OP_READOUT, 32'h0);
		repeat (3) send_word(OP_CORRELATE, random_sample());
		send_word(OP_READOUT, 32'h0);
		drain_and_settle();
	endtask

	// mostly restart, correlate run, readout; with noise and config changes
	task automatic test_random_runs();
		int unsigned target;
		int unsigned run_len;
		int unsigned pick;
		target = words_sent + RANDOM_WORDS;
		while (words_sent < target) begin
			tx_gaps_on   = ($urandom_range(3) != 0);
			rx_stalls_on = ($urandom_range(3) != 0);
			if ($urandom_range(99) < 25) begin
				drain_and_settle();
				write_reg(REG_TAP_MASK, random_tap());
				if ($urandom_range(1) != 0)
					write_reg(REG_SEED, 16'($urandom_range(16'hFFFF, 1)));
			end
			if ($urandom_range(9) != 0)
				send_word(OP_RESTART, $urandom());
			run_len = $urandom_range(12, 1);
			repeat (run_len) begin
				pick = $urandom_range(99);
				if (pick < 4)
					send_word(OP_UNUSED, $urandom());
				else if (pick < 8)
					send_word(OP_READOUT, $urandom());
				else if (pick < 11)
					send_word(OP_RESTART, $urandom());
				else
					send_word(OP_CORRELATE, random_sample());
			end
			send_word(OP_READOUT, $urandom());
		end
		drain_and_settle();
	endtask

	// ---------------------------------------------------------------- main

	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = REG_TAP_MASK;
		cfg_data              = '0;
		sample_ch.valid       = 1'b0;
		sample_ch.operation   = OP_RESTART;
		sample_ch.sample_word = '0;
		words_sent   = 0;
		burst_left   = 0;
		hold_request = 0;
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		tap_model    = TAP_RESET;
		seed_model   = SEED_RESET;
		clear_model_run();

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_reset_readout();
		test_operations();
		test_register_extremes();
		test_backpressure();
		test_random_runs();

		if (mismatches == 0)
			$display("PASS pn_sequence_correlator");
		else
			$display("FAIL pn_sequence_correlator");
		$finish;
	end

endmodule
